/* rtl/dht_pkg.sv */
// ----------------------------------------------------------------------------
// dht_pkg
// Shared types, constants and hash functions of the double hash table.
// ----------------------------------------------------------------------------
package dht_pkg;

    localparam int TABLE_LOG2  = 10;
    localparam int EXPIRE_CAP  = 63;
    localparam int HANDLE_BITS = 16;

    localparam int TSIZE   = 1 << TABLE_LOG2;
    localparam int IDX_W   = TABLE_LOG2;
    localparam int OCC_W   = TABLE_LOG2 + 1;
    localparam int DONE_W  = $clog2(EXPIRE_CAP + 1);
    localparam int MAXP_W  = 10;
    localparam int PROBE_W = MAXP_W + 1;
    localparam int ENT_W   = 64 + HANDLE_BITS;

    localparam int SLOT_F_W   = 10;
    localparam int HANDLE_F_W = 16;
    localparam int OCNT_F_W   = 11;

    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_FIND,
        OP_SUBMIT,
        OP_EXPIRE
    } op_t;

    typedef enum logic [2:0] {
        K_INSERTED,
        K_REFUSED,
        K_FOUND,
        K_NOTFOUND,
        K_RELEASED,
        K_DONE
    } kind_t;

    typedef struct packed {
        op_t                    op;
        logic [31:0]            key;
        logic [HANDLE_BITS-1:0] handle;
        logic [31:0]            stamp;
        logic [IDX_W-1:0]       sin;
        logic [31:0]            h;
        logic [31:0]            h2;
    } item_t;

    typedef struct packed {
        kind_t                  kind;
        logic [IDX_W-1:0]       slot;
        logic [31:0]            key;
        logic [HANDLE_BITS-1:0] handle;
        logic                   inc;
        logic                   more;
        logic                   last;
    } res_t;

    typedef struct packed {
        logic [MAXP_W-1:0] probe_limit;
        logic [31:0]       min_life;
    } cfg_t;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int r);
        return (v >> r) | (v << (32 - r));
    endfunction

    function automatic logic [31:0] hf_a(input logic [31:0] v);
        logic [31:0] n;
        n = v;
        n = n + (n << 12);
        n = n ^ (n >> 22);
        n = n + (n << 4);
        n = n ^ (n >> 9);
        return n;
    endfunction

    function automatic logic [31:0] hf_b(input logic [31:0] v);
        logic [31:0] n;
        n = v;
        n = n + (n << 10);
        n = n ^ (n >> 2);
        n = n + (n << 7);
        n = n ^ (n >> 12);
        return n;
    endfunction

    function automatic logic [31:0] hs_a(input logic [31:0] v);
        logic [31:0] n;
        n = v;
        n = ~n + (n << 15);
        n = n ^ rotr(n, 12);
        n = n + (n << 2);
        return n;
    endfunction

    function automatic logic [31:0] hs_b(input logic [31:0] v);
        logic [31:0] n;
        n = v;
        n = n ^ rotr(n, 4);
        n = (n + (n << 3)) + (n << 11);
        n = n ^ rotr(n, 16);
        return n;
    endfunction

endpackage

/* rtl/double_hash_table_with_expiry_top.sv */
// ----------------------------------------------------------------------------
// double_hash_table_with_expiry_top
// Open-addressed key table with double hashing, eviction and ordered expiry.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  tuser op, tdata key/handle/stamp/slot_in
//  m_       out  m_tvalid/m_tready  tuser kind, tlast last, tdata result
//  cfg_     in   cfg_we             cfg_addr register, cfg_wdata value
//
//  Front: an s_ accept passes two hash stages and a queue to reach the sequencer.
//  Find, refuse: each probed slot is read and checked in turn; insert claims a slot, after a release on eviction.
//  Submit releases the given slot if it is open; expire releases due entries one by one, then reports done.
//  After reset a clearing pass over all 1024 slots runs before s_tready rises.
//  A stalled m_ side holds the sequencer; the front keeps hashing into its queue until it is full.
// ----------------------------------------------------------------------------
module double_hash_table_with_expiry_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // op
    input  logic [95:0] s_tdata,   // key, handle, stamp, slot_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast,
    output logic [71:0] m_tdata,   // slot, key_out, handle_out, incomplete, more, open_count
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata
);

    dht_pkg::cfg_t  cfg_reg;
    dht_pkg::item_t q_item;
    dht_pkg::res_t  res;
    logic q_valid, q_pop, run;
    logic [dht_pkg::OCC_W-1:0] occ;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{probe_limit: dht_pkg::MAXP_W'(8), min_life: '0};
        end else if (cfg_we) begin
            if (cfg_addr) begin
                cfg_reg <= '{probe_limit: cfg_reg.probe_limit, min_life: cfg_wdata};
            end else begin
                cfg_reg <= '{probe_limit: cfg_wdata[dht_pkg::MAXP_W-1:0],
                             min_life: cfg_reg.min_life};
            end
        end
    end

    dht_front u_front (
        .aclk(aclk), .aresetn(aresetn), .run(run),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_op(dht_pkg::op_t'(s_tuser)),
        .in_key(s_tdata[31:0]),
        .in_handle(s_tdata[32 +: dht_pkg::HANDLE_BITS]),
        .in_stamp(s_tdata[79:48]),
        .in_sin(s_tdata[80 +: dht_pkg::IDX_W]),
        .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
    );

    dht_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop), .run(run),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_res(res), .m_occ(occ)
    );

    assign m_tuser = res.kind;
    assign m_tlast = res.last;
    assign m_tdata = {1'b0,
                      dht_pkg::OCNT_F_W'(occ),
                      res.more,
                      res.inc,
                      dht_pkg::HANDLE_F_W'(res.handle),
                      res.key,
                      dht_pkg::SLOT_F_W'(res.slot)};

    a_more_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[59] |-> m_tuser == dht_pkg::K_DONE)
        else $error("more_pending on a result other than expire done");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == dht_pkg::K_DONE || m_tuser == dht_pkg::K_REFUSED ||
                     m_tuser == dht_pkg::K_FOUND || m_tuser == dht_pkg::K_INSERTED) |-> m_tlast)
        else $error("final result kind without last");

    a_release_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == dht_pkg::K_RELEASED && !m_tlast |-> m_tdata[58])
        else $error("non-final release not marked incomplete");

    a_occ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[70:60] <= 11'(dht_pkg::TSIZE))
        else $error("open_count beyond table size");

endmodule

/* rtl/dht_ram.sv */
// ----------------------------------------------------------------------------
// dht_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module dht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/dht_front.sv */
// ----------------------------------------------------------------------------
// dht_front
// Accepts items, computes both key hashes over two stages, queues the work.
// ----------------------------------------------------------------------------
module dht_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            run,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  dht_pkg::op_t                    in_op,
    input  logic [31:0]                     in_key,
    input  logic [dht_pkg::HANDLE_BITS-1:0] in_handle,
    input  logic [31:0]                     in_stamp,
    input  logic [dht_pkg::IDX_W-1:0]       in_sin,
    output dht_pkg::item_t                  q_item,
    output logic                            q_valid,
    input  logic                            q_pop
);

    logic           v1_reg, v2_reg;
    dht_pkg::item_t it1_reg, it2_reg;
    dht_pkg::item_t q_reg [dht_pkg::QDEPTH];
    logic [dht_pkg::QA_W-1:0] wp_reg, rp_reg;
    logic [dht_pkg::QA_W:0]   cnt_reg;
    logic full, push, pop, en1, en2;

    assign full     = (cnt_reg == (dht_pkg::QA_W+1)'(dht_pkg::QDEPTH));
    assign push     = v2_reg && !full;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_valid && q_pop;
    assign en2      = !v2_reg || push;
    assign en1      = !v1_reg || en2;
    assign in_ready = run && en1;
    assign q_item   = q_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid && in_ready;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (push) begin
                wp_reg <= wp_reg + dht_pkg::QA_W'(1);
            end
            if (pop) begin
                rp_reg <= rp_reg + dht_pkg::QA_W'(1);
            end
            cnt_reg <= cnt_reg + (dht_pkg::QA_W+1)'(push) - (dht_pkg::QA_W+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            it1_reg <= '{op: in_op, key: in_key, handle: in_handle, stamp: in_stamp,
                         sin: in_sin, h: dht_pkg::hf_a(in_key), h2: dht_pkg::hs_a(in_key)};
        end
        if (en2) begin
            it2_reg <= '{op: it1_reg.op, key: it1_reg.key, handle: it1_reg.handle,
                         stamp: it1_reg.stamp, sin: it1_reg.sin,
                         h: dht_pkg::hf_b(it1_reg.h), h2: dht_pkg::hs_b(it1_reg.h2)};
        end
        if (push) begin
            q_reg[wp_reg] <= it2_reg;
        end
    end

endmodule

/* rtl/dht_back.sv */
// ----------------------------------------------------------------------------
// dht_back
// Sequencer that probes, claims, releases and expires table slots.
// ----------------------------------------------------------------------------
module dht_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  dht_pkg::cfg_t             cfg,
    input  dht_pkg::item_t            q_item,
    input  logic                      q_valid,
    output logic                      q_pop,
    output logic                      run,
    output logic                      m_valid,
    input  logic                      m_ready,
    output dht_pkg::res_t             m_res,
    output logic [dht_pkg::OCC_W-1:0] m_occ
);

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_P_RD, ST_P_CHK, ST_S_RD, ST_S_CHK, ST_X_RD, ST_X_CHK,
        ST_R_RD, ST_R_UPD, ST_CLAIM, ST_EMIT
    } state_t;

    localparam int IW = dht_pkg::IDX_W;
    localparam int HB = dht_pkg::HANDLE_BITS;

    state_t state_reg, ret_reg;
    dht_pkg::item_t it_reg;
    dht_pkg::res_t  res_reg, m_res_reg;
    logic [31:0] h_reg;
    logic [dht_pkg::PROBE_W-1:0] probes_reg;
    logic [IW-1:0] oldest_reg, s_reg, head_reg, tail_reg, clr_reg;
    logic [31:0] otime_reg, ckey_reg;
    logic [HB-1:0] chdl_reg;
    logic [dht_pkg::DONE_W-1:0] done_reg;
    logic [dht_pkg::OCC_W-1:0] occ_reg, m_occ_reg;
    logic m_valid_reg;

    logic open_we, ent_we, nxt_we, prv_we;
    logic [IW-1:0] open_wa, open_ra, ent_wa, ent_ra, nxt_wa, prv_wa;
    logic [0:0] open_wd, open_rd;
    logic [dht_pkg::ENT_W-1:0] ent_wd, ent_rd;
    logic [IW-1:0] nxt_wd, prv_wd, nxt_rd, prv_rd;

    logic [IW-1:0] idx, o_slot;
    logic [31:0] e_key, e_time, o_time, o_key;
    logic [HB-1:0] e_hdl, o_hdl;
    logic upd, more_probes, evict_ok, hit, due, out_free, emit_now;

    function automatic dht_pkg::res_t mk_res(input dht_pkg::kind_t k, input logic [IW-1:0] s,
                                             input logic [31:0] kv, input logic [HB-1:0] hv,
                                             input logic inc, input logic more,
                                             input logic last);
        dht_pkg::res_t r;
        r.kind   = k;
        r.slot   = s;
        r.key    = kv;
        r.handle = hv;
        r.inc    = inc;
        r.more   = more;
        r.last   = last;
        return r;
    endfunction

    assign idx   = h_reg[IW-1:0];
    assign e_key  = ent_rd[dht_pkg::ENT_W-1 -: 32];
    assign e_time = ent_rd[HB +: 32];
    assign e_hdl  = ent_rd[HB-1:0];

    assign upd         = (probes_reg == '0) || (e_time < otime_reg);
    assign o_slot      = upd ? idx : oldest_reg;
    assign o_time      = upd ? e_time : otime_reg;
    assign o_key       = upd ? e_key : ckey_reg;
    assign o_hdl       = upd ? e_hdl : chdl_reg;
    assign more_probes = probes_reg <= dht_pkg::PROBE_W'(cfg.probe_limit);
    assign evict_ok    = ({1'b0, o_time} + {1'b0, cfg.min_life}) <= {1'b0, it_reg.stamp};
    assign hit         = open_rd[0] && (e_key == it_reg.key);
    assign due         = (occ_reg != '0) && (e_time <= it_reg.stamp);
    assign out_free    = !m_valid_reg || m_ready;
    assign emit_now    = (state_reg == ST_EMIT) && out_free;

    assign q_pop   = (state_reg == ST_IDLE);
    assign run     = (state_reg != ST_CLR);
    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;
    assign m_occ   = m_occ_reg;

    always_comb begin
        open_we = 1'b0;
        open_wa = s_reg;
        open_wd = 1'b0;
        open_ra = idx;
        ent_we  = 1'b0;
        ent_wa  = s_reg;
        ent_wd  = {it_reg.key, it_reg.stamp, it_reg.handle};
        ent_ra  = idx;
        nxt_we  = 1'b0;
        nxt_wa  = prv_rd;
        nxt_wd  = nxt_rd;
        prv_we  = 1'b0;
        prv_wa  = nxt_rd;
        prv_wd  = prv_rd;
        case (state_reg)
            ST_CLR: begin
                open_we = 1'b1;
                open_wa = clr_reg;
            end
            ST_S_RD: begin
                open_ra = it_reg.sin;
                ent_ra  = it_reg.sin;
            end
            ST_X_RD: begin
                ent_ra = head_reg;
            end
            ST_R_UPD: begin
                open_we = 1'b1;
                if (occ_reg > dht_pkg::OCC_W'(1) && s_reg != head_reg && s_reg != tail_reg) begin
                    nxt_we = 1'b1;
                    prv_we = 1'b1;
                end
            end
            ST_CLAIM: begin
                open_we = 1'b1;
                open_wd = 1'b1;
                ent_we  = 1'b1;
                if (occ_reg != '0) begin
                    nxt_we = 1'b1;
                    nxt_wa = tail_reg;
                    nxt_wd = s_reg;
                    prv_we = 1'b1;
                    prv_wa = s_reg;
                    prv_wd = tail_reg;
                end
            end
            default: begin
            end
        endcase
    end

    dht_ram #(.WIDTH(1), .DEPTH(dht_pkg::TSIZE)) u_open (
        .aclk(aclk), .we(open_we), .waddr(open_wa), .wdata(open_wd),
        .raddr(open_ra), .rdata(open_rd)
    );

    dht_ram #(.WIDTH(dht_pkg::ENT_W), .DEPTH(dht_pkg::TSIZE)) u_ent (
        .aclk(aclk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd),
        .raddr(ent_ra), .rdata(ent_rd)
    );

    dht_ram #(.WIDTH(IW), .DEPTH(dht_pkg::TSIZE)) u_next (
        .aclk(aclk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
        .raddr(s_reg), .rdata(nxt_rd)
    );

    dht_ram #(.WIDTH(IW), .DEPTH(dht_pkg::TSIZE)) u_prev (
        .aclk(aclk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
        .raddr(s_reg), .rdata(prv_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            ret_reg     <= ST_IDLE;
            clr_reg     <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit_now) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLR: begin
                    clr_reg <= clr_reg + IW'(1);
                    if (clr_reg == '1) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (q_valid) begin
                        it_reg     <= q_item;
                        h_reg      <= q_item.h;
                        probes_reg <= '0;
                        done_reg   <= '0;
                        case (q_item.op)
                            dht_pkg::OP_INSERT, dht_pkg::OP_FIND: state_reg <= ST_P_RD;
                            dht_pkg::OP_SUBMIT: state_reg <= ST_S_RD;
                            default: state_reg <= ST_X_RD;
                        endcase
                    end
                end
                ST_P_RD: begin
                    state_reg <= ST_P_CHK;
                end
                ST_P_CHK: begin
                    ret_reg <= ST_IDLE;
                    if (it_reg.op == dht_pkg::OP_INSERT) begin
                        if (!open_rd[0]) begin
                            s_reg     <= idx;
                            state_reg <= ST_CLAIM;
                        end else begin
                            oldest_reg <= o_slot;
                            otime_reg  <= o_time;
                            ckey_reg   <= o_key;
                            chdl_reg   <= o_hdl;
                            if (more_probes) begin
                                h_reg      <= h_reg + it_reg.h2;
                                probes_reg <= probes_reg + dht_pkg::PROBE_W'(1);
                                state_reg  <= ST_P_RD;
                            end else if (evict_ok) begin
                                s_reg     <= o_slot;
                                state_reg <= ST_R_RD;
                            end else begin
                                res_reg   <= mk_res(dht_pkg::K_REFUSED, o_slot, '0, '0,
                                                    1'b0, 1'b0, 1'b1);
                                state_reg <= ST_EMIT;
                            end
                        end
                    end else begin
                        if (hit) begin
                            res_reg   <= mk_res(dht_pkg::K_FOUND, idx, e_key, e_hdl,
                                                1'b0, 1'b0, 1'b1);
                            state_reg <= ST_EMIT;
                        end else if (more_probes) begin
                            h_reg      <= h_reg + it_reg.h2;
                            probes_reg <= probes_reg + dht_pkg::PROBE_W'(1);
                            state_reg  <= ST_P_RD;
                        end else begin
                            res_reg   <= mk_res(dht_pkg::K_NOTFOUND, '0, '0, '0,
                                                1'b0, 1'b0, 1'b1);
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_S_RD: begin
                    state_reg <= ST_S_CHK;
                end
                ST_S_CHK: begin
                    s_reg    <= it_reg.sin;
                    ckey_reg <= e_key;
                    chdl_reg <= e_hdl;
                    if (open_rd[0]) begin
                        state_reg <= ST_R_RD;
                    end else begin
                        res_reg   <= mk_res(dht_pkg::K_NOTFOUND, it_reg.sin, '0, '0,
                                            1'b0, 1'b0, 1'b1);
                        ret_reg   <= ST_IDLE;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_X_RD: begin
                    state_reg <= ST_X_CHK;
                end
                ST_X_CHK: begin
                    if (due && done_reg != dht_pkg::DONE_W'(dht_pkg::EXPIRE_CAP)) begin
                        s_reg     <= head_reg;
                        ckey_reg  <= e_key;
                        chdl_reg  <= e_hdl;
                        done_reg  <= done_reg + dht_pkg::DONE_W'(1);
                        state_reg <= ST_R_RD;
                    end else begin
                        res_reg   <= mk_res(dht_pkg::K_DONE, '0, '0, '0, 1'b0, due, 1'b1);
                        ret_reg   <= ST_IDLE;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_R_RD: begin
                    state_reg <= ST_R_UPD;
                end
                ST_R_UPD: begin
                    if (occ_reg > dht_pkg::OCC_W'(1)) begin
                        if (s_reg == head_reg) begin
                            head_reg <= nxt_rd;
                        end else if (s_reg == tail_reg) begin
                            tail_reg <= prv_rd;
                        end
                    end
                    if (occ_reg != '0) begin
                        occ_reg <= occ_reg - dht_pkg::OCC_W'(1);
                    end
                    res_reg <= mk_res(dht_pkg::K_RELEASED, s_reg, ckey_reg, chdl_reg,
                                      (it_reg.op != dht_pkg::OP_SUBMIT), 1'b0,
                                      (it_reg.op == dht_pkg::OP_SUBMIT));
                    case (it_reg.op)
                        dht_pkg::OP_INSERT: ret_reg <= ST_CLAIM;
                        dht_pkg::OP_EXPIRE: ret_reg <= ST_X_RD;
                        default: ret_reg <= ST_IDLE;
                    endcase
                    state_reg <= ST_EMIT;
                end
                ST_CLAIM: begin
                    if (occ_reg == '0) begin
                        head_reg <= s_reg;
                    end
                    tail_reg  <= s_reg;
                    occ_reg   <= occ_reg + dht_pkg::OCC_W'(1);
                    res_reg   <= mk_res(dht_pkg::K_INSERTED, s_reg, it_reg.key, it_reg.handle,
                                        1'b0, 1'b0, 1'b1);
                    ret_reg   <= ST_IDLE;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_res_reg <= res_reg;
                        m_occ_reg <= occ_reg;
                        state_reg <= ret_reg;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* tb/sv/tb_double_hash_table_with_expiry_top.sv */
// ----------------------------------------------------------------------------
// tb_double_hash_table_with_expiry_top
// Self-checking bench for the double hash table with expiry. A scoreboard
// keeps its own copy of the table and insertion order, predicts every result
// word of each accepted op and checks the result stream in order, while the
// sender bursts and the receiver stalls at random under several register sets.
// ----------------------------------------------------------------------------
module tb_double_hash_table_with_expiry_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMEOUT_CYCLES = 1_500_000;

    typedef struct {
        dht_pkg::kind_t kind;
        logic [9:0]     slot;
        logic [31:0]    key;
        logic [15:0]    handle;
        logic           inc;
        logic           more;
        logic [10:0]    ocnt;
        logic           last;
    } word_t;

    class table_scoreboard;
        bit          open_q [1024];
        logic [31:0] key_q  [1024];
        logic [31:0] time_q [1024];
        logic [15:0] hdl_q  [1024];
        logic [9:0]  prev_q [1024];
        logic [9:0]  next_q [1024];
        logic [9:0]  head, tail;
        int          occ;
        logic [9:0]  probe_limit;
        logic [31:0] min_life;
        word_t       pending[$];
        int          mismatches;

        function new();
            foreach (open_q[i]) open_q[i] = 0;
            head = 0; tail = 0; occ = 0;
            probe_limit = 8; min_life = 0; mismatches = 0;
        endfunction

        function logic [31:0] spin_r(logic [31:0] v, int r);
            logic [63:0] d;
            d = {v, v} >> r;
            return d[31:0];
        endfunction

        function logic [31:0] home_hash(logic [31:0] v);
            v += v << 12; v ^= v >> 22; v += v << 4;  v ^= v >> 9;
            v += v << 10; v ^= v >> 2;  v += v << 7;  v ^= v >> 12;
            return v;
        endfunction

        function logic [31:0] stride_hash(logic [31:0] v);
            v = ~v + (v << 15);
            v ^= spin_r(v, 12);
            v += v << 2;
            v ^= spin_r(v, 4);
            v = (v + (v << 3)) + (v << 11);
            v ^= spin_r(v, 16);
            return v;
        endfunction

        function void push(dht_pkg::kind_t k, logic [9:0] s, logic [31:0] kv,
                           logic [15:0] hv, logic inc, logic more);
            word_t w;
            w.kind = k; w.slot = s; w.key = kv; w.handle = hv;
            w.inc = inc; w.more = more; w.ocnt = occ[10:0]; w.last = 0;
            pending.push_back(w);
        endfunction

        function void unlink(logic [9:0] s);
            if (occ > 1) begin
                if (s == head) head = next_q[s];
                else if (s == tail) tail = prev_q[s];
                else begin
                    next_q[prev_q[s]] = next_q[s];
                    prev_q[next_q[s]] = prev_q[s];
                end
            end
            open_q[s] = 0;
            if (occ > 0) occ--;
        endfunction

        function void note_input(dht_pkg::op_t op, logic [31:0] kv, logic [15:0] hv,
                                 logic [31:0] stamp, logic [9:0] sin);
            logic [31:0] h, h2;
            logic [9:0]  idx, oldest;
            int          probes, done;
            bit          hit;
            h = home_hash(kv); h2 = stride_hash(kv);
            idx = h[9:0]; probes = 0;
            case (op)
                dht_pkg::OP_INSERT: begin
                    oldest = idx;
                    hit = !open_q[idx];
                    while (!hit && probes <= probe_limit) begin
                        h += h2; idx = h[9:0]; probes++;
                        if (!open_q[idx]) hit = 1;
                        else if (time_q[idx] < time_q[oldest]) oldest = idx;
                    end
                    if (!hit) begin
                        if ({1'b0, time_q[oldest]} + {1'b0, min_life} > {1'b0, stamp}) begin
                            push(dht_pkg::K_REFUSED, oldest, '0, '0, 1'b0, 1'b0);
                            pending[$].last = 1;
                            return;
                        end
                        unlink(oldest);
                        push(dht_pkg::K_RELEASED, oldest, key_q[oldest], hdl_q[oldest],
                             1'b1, 1'b0);
                        idx = oldest;
                    end
                    open_q[idx] = 1; key_q[idx] = kv; hdl_q[idx] = hv; time_q[idx] = stamp;
                    if (occ == 0) begin
                        head = idx; tail = idx;
                    end else begin
                        next_q[tail] = idx; prev_q[idx] = tail; tail = idx;
                    end
                    occ++;
                    push(dht_pkg::K_INSERTED, idx, kv, hv, 1'b0, 1'b0);
                end
                dht_pkg::OP_FIND: begin
                    hit = open_q[idx] && key_q[idx] == kv;
                    while (!hit && probes <= probe_limit) begin
                        h += h2; idx = h[9:0]; probes++;
                        hit = open_q[idx] && key_q[idx] == kv;
                    end
                    if (hit) push(dht_pkg::K_FOUND, idx, key_q[idx], hdl_q[idx], 1'b0, 1'b0);
                    else push(dht_pkg::K_NOTFOUND, '0, '0, '0, 1'b0, 1'b0);
                end
                dht_pkg::OP_SUBMIT: begin
                    if (open_q[sin]) begin
                        unlink(sin);
                        push(dht_pkg::K_RELEASED, sin, key_q[sin], hdl_q[sin], 1'b0, 1'b0);
                    end else begin
                        push(dht_pkg::K_NOTFOUND, sin, '0, '0, 1'b0, 1'b0);
                    end
                end
                default: begin
                    done = 0;
                    while (occ > 0 && done < dht_pkg::EXPIRE_CAP && time_q[head] <= stamp) begin
                        idx = head;
                        unlink(idx);
                        push(dht_pkg::K_RELEASED, idx, key_q[idx], hdl_q[idx], 1'b1, 1'b0);
                        done++;
                    end
                    push(dht_pkg::K_DONE, '0, '0, '0, 1'b0, occ > 0 && time_q[head] <= stamp);
                end
            endcase
            pending[$].last = 1;
        endfunction

        function void check(word_t got);
            word_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word kind=%0d slot=%0d", got.kind, got.slot);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.slot !== want.slot || got.key !== want.key ||
                got.handle !== want.handle || got.inc !== want.inc ||
                got.more !== want.more || got.ocnt !== want.ocnt || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch exp kind=%0d slot=%0d key=%h hdl=%h inc=%b more=%b cnt=%0d last=%b",
                             want.kind, want.slot, want.key, want.handle, want.inc,
                             want.more, want.ocnt, want.last);
                    $display("         got kind=%0d slot=%0d key=%h hdl=%h inc=%b more=%b cnt=%0d last=%b",
                             got.kind, got.slot, got.key, got.handle, got.inc,
                             got.more, got.ocnt, got.last);
                end
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic [71:0] m_tdata;
    logic        cfg_we = 0;
    logic        cfg_addr = 0;
    logic [31:0] cfg_wdata = '0;

    table_scoreboard table_sb = new();
    int          cycles = 0;
    int          words_in = 0;
    bit          hold_req = 0;
    int          burst_left = 0;
    logic [31:0] now = 32'd100;
    logic [31:0] key_pool[6];
    logic [31:0] seen_keys[$];

    double_hash_table_with_expiry_top uut (.*);

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= TIMEOUT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // input and result monitors
    always @(posedge aclk) begin
        word_t w;
        if (aresetn && s_tvalid && s_tready) begin
            table_sb.note_input(dht_pkg::op_t'(s_tuser), s_tdata[31:0], s_tdata[47:32],
                                s_tdata[79:48], s_tdata[89:80]);
            words_in <= words_in + 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            w.kind = dht_pkg::kind_t'(m_tuser); w.slot = m_tdata[9:0]; w.key = m_tdata[41:10];
            w.handle = m_tdata[57:42]; w.inc = m_tdata[58]; w.more = m_tdata[59];
            w.ocnt = m_tdata[70:60]; w.last = m_tlast;
            table_sb.check(w);
        end
    end

    // receiver: random stall patterns plus one long hold-off
    initial begin
        int mode, len, held;
        forever begin
            if (hold_req) begin
                held = 0;
                while (held < 3000) begin
                    @(posedge aclk);
                    m_tready <= 0;
                    held++;
                end
                hold_req = 0;
            end
            mode = $urandom_range(0, 2);
            len = $urandom_range(5, 60);
            repeat (len) begin
                @(posedge aclk);
                case (mode)
                    0: m_tready <= 1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // called at a clock edge; returns at the edge that accepted the word
    task automatic send_word(dht_pkg::op_t op, logic [31:0] kv, logic [15:0] hv,
                             logic [31:0] stamp, logic [9:0] sin);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {6'd0, sin, stamp, hv, kv};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        burst_left = 0;
        while (table_sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        if (idx) table_sb.min_life = val;
        else table_sb.probe_limit = val[9:0];
    endtask

    task automatic random_words(int n, bit with_hold);
        int           pick, i;
        dht_pkg::op_t op;
        logic [31:0]  kv, stamp;
        for (i = 0; i < n; i++) begin
            if (with_hold && i == n / 2) hold_req = 1;
            now += $urandom_range(0, 8);
            pick = $urandom_range(0, 99);
            kv = $urandom();
            stamp = now;
            if (pick < 50) begin
                op = dht_pkg::OP_INSERT;
                if ($urandom_range(0, 1)) kv = key_pool[$urandom_range(0, 5)];
                if ($urandom_range(0, 19) == 0) stamp = $urandom();
                seen_keys.push_back(kv);
            end else if (pick < 70) begin
                op = dht_pkg::OP_FIND;
                if (seen_keys.size() > 0 && $urandom_range(0, 3) != 0)
                    kv = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
            end else if (pick < 85) begin
                op = dht_pkg::OP_SUBMIT;
            end else begin
                op = dht_pkg::OP_EXPIRE;
                stamp = $urandom_range(0, 9) == 0 ? 32'hFFFF_FFFF : now - $urandom_range(0, 300);
            end
            send_word(op, kv, 16'($urandom()), stamp,
                      10'($urandom_range(0, 2) == 0 ?
                          table_sb.home_hash(key_pool[$urandom_range(0, 5)]) : $urandom()));
        end
    endtask

    initial begin
        int i;
        foreach (key_pool[i]) key_pool[i] = $urandom();
        repeat (12) @(posedge aclk);
        aresetn <= 1;

        // edges of the fields, every op, eviction, submit of an empty slot
        send_word(dht_pkg::OP_INSERT, 32'h0, 16'h0, 32'h0, 10'd0);
        send_word(dht_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 10'd1023);
        send_word(dht_pkg::OP_FIND, 32'h0, 16'h0, 32'h0, 10'd0);
        send_word(dht_pkg::OP_FIND, 32'hFFFF_FFFF, 16'h0, 32'h0, 10'd0);
        send_word(dht_pkg::OP_FIND, 32'h1234_5678, 16'h0, 32'h0, 10'd0);
        for (i = 0; i < 11; i++)
            send_word(dht_pkg::OP_INSERT, 32'hA5A5_0001, i[15:0], 32'd10 + i, 10'd0);
        send_word(dht_pkg::OP_SUBMIT, 32'h0, 16'h0, 32'h0, 10'(table_sb.home_hash(32'h0)));
        send_word(dht_pkg::OP_SUBMIT, 32'h0, 16'h0, 32'h0, 10'd1023);
        send_word(dht_pkg::OP_SUBMIT, 32'h0, 16'h0, 32'h0, 10'd0);
        send_word(dht_pkg::OP_EXPIRE, 32'h0, 16'h0, 32'd0, 10'd0);
        send_word(dht_pkg::OP_EXPIRE, 32'h0, 16'h0, 32'd14, 10'd0);
        send_word(dht_pkg::OP_EXPIRE, 32'h0, 16'h0, 32'hFFFF_FFFF, 10'd0);
        random_words(200, 1);
        drain();

        write_reg(1'b0, 32'd0);
        write_reg(1'b1, 32'hFFFF_FFFF);
        random_words(100, 0);
        drain();

        write_reg(1'b0, 32'd1023);
        write_reg(1'b1, 32'd0);
        random_words(20, 0);
        drain();

        write_reg(1'b0, 32'd5);
        write_reg(1'b1, 32'd50);
        random_words(100, 0);
        send_word(dht_pkg::OP_EXPIRE, 32'h0, 16'h0, 32'hFFFF_FFFF, 10'd0);
        send_word(dht_pkg::OP_EXPIRE, 32'h0, 16'h0, 32'hFFFF_FFFF, 10'd0);
        drain();
        repeat (2200) @(posedge aclk);

        if (table_sb.mismatches == 0 && table_sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
